// ----- src/mmul_pkg.sv -----
// Shared types and constants for the modular multiplier core.
// Used by mmul_unit and modular_multiplier_core; depends on nothing.
package mmul_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_MOD = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic carry_clr;
		logic sub_en;
		logic sub_first;
	} unit_ctrl_t;

endpackage

// ----- src/mmul_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated by modular_multiplier_core for every word store.
module mmul_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/mmul_unit.sv -----
// Shared arithmetic unit: 32x32 multiply-accumulate for the product and a
// word-serial shift-and-subtract for the reduction. Depends on mmul_pkg.
module mmul_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mmul_pkg::unit_ctrl_t      ctrl,
	input  logic [mmul_pkg::WORD_W-1:0] a_word,
	input  logic [mmul_pkg::WORD_W-1:0] b_word,
	input  logic [mmul_pkg::WORD_W-1:0] p_word,
	input  logic [mmul_pkg::WORD_W-1:0] r_word,
	input  logic [mmul_pkg::WORD_W-1:0] m_word,
	input  logic                      bit_in,
	output logic [mmul_pkg::WORD_W-1:0] acc_lo,
	output logic [mmul_pkg::WORD_W-1:0] carry,
	output logic [mmul_pkg::WORD_W-1:0] sh_word,
	output logic [mmul_pkg::WORD_W-1:0] diff_word,
	output logic                      ge
);

	logic [2*mmul_pkg::WORD_W-1:0] mult_q;
	logic [2*mmul_pkg::WORD_W-1:0] sum;
	logic [mmul_pkg::WORD_W-1:0]   carry_q;
	logic                          shc_q;
	logic                          bor_q;
	logic                          cin;
	logic                          bin;
	logic [mmul_pkg::WORD_W:0]     diff;

	assign sum = mult_q + {{mmul_pkg::WORD_W{1'b0}}, p_word}
		+ {{mmul_pkg::WORD_W{1'b0}}, carry_q};
	assign acc_lo = sum[mmul_pkg::WORD_W-1:0];
	assign carry = carry_q;

	assign cin = ctrl.sub_first ? bit_in : shc_q;
	assign bin = ctrl.sub_first ? 1'b0 : bor_q;
	assign sh_word = {r_word[mmul_pkg::WORD_W-2:0], cin};
	assign diff = {1'b0, sh_word} - {1'b0, m_word} - {{mmul_pkg::WORD_W{1'b0}}, bin};
	assign diff_word = diff[mmul_pkg::WORD_W-1:0];
	assign ge = r_word[mmul_pkg::WORD_W-1] | ~diff[mmul_pkg::WORD_W];

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			mult_q <= 64'(a_word) * 64'(b_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			shc_q <= 1'b0;
			bor_q <= 1'b0;
		end else begin
			if (ctrl.carry_clr) begin
				carry_q <= '0;
			end else if (ctrl.acc_en) begin
				carry_q <= sum[2*mmul_pkg::WORD_W-1:mmul_pkg::WORD_W];
			end
			if (ctrl.sub_en) begin
				shc_q <= r_word[mmul_pkg::WORD_W-1];
				bor_q <= diff[mmul_pkg::WORD_W];
			end
		end
	end

endmodule

// ----- src/modular_multiplier_core.sv -----
// Multiword modular multiplier a*b mod p: sequencer, word stores and top level.
// Depends on mmul_pkg, mmul_ram and mmul_unit.
// Operands are loaded beat by beat; the work for n words is set mainly by the word-serial
// shift-subtract pass run for each product bit, and the result is then sent out beat by beat.
// One operation at a time; input is held off meanwhile.
// Reset clears the sequencer, counters and flags; the word stores are not cleared.
module modular_multiplier_core #(
	parameter int MAX_WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // a_word[31:0], b_word[63:32], mod_word[95:64]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // result_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast,
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int PW = $clog2(2 * MAX_WORDS);
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int W = mmul_pkg::WORD_W;

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_PR_RD = 4'd2;
	localparam logic [3:0] ST_PR_MUL = 4'd3;
	localparam logic [3:0] ST_PR_ACC = 4'd4;
	localparam logic [3:0] ST_PR_CAR = 4'd5;
	localparam logic [3:0] ST_RW_RD = 4'd6;
	localparam logic [3:0] ST_RW_LD = 4'd7;
	localparam logic [3:0] ST_S1_RD = 4'd8;
	localparam logic [3:0] ST_S1_CMP = 4'd9;
	localparam logic [3:0] ST_S2_RD = 4'd10;
	localparam logic [3:0] ST_S2_WR = 4'd11;
	localparam logic [3:0] ST_OUT_RD = 4'd12;
	localparam logic [3:0] ST_OUT_LD = 4'd13;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          nz_q;
	logic [CW-1:0] n_q;
	logic [mmul_pkg::STATUS_W-1:0] status_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic [PW-1:0] pc_q;
	logic [PW-1:0] wdx_q;
	logic [4:0]    bit_q;
	logic [W-1:0]  pw_q;
	logic          ge_q;
	logic [mmul_pkg::IDX_W-1:0] oidx_q;
	logic          ovalid_q;
	logic [W-1:0]  odata_q;
	logic [mmul_pkg::IDX_W-1:0] oindex_q;
	logic          olast_q;
	logic [mmul_pkg::STATUS_W-1:0] ostatus_q;

	logic          in_acc;
	logic          store_en;
	logic [CW-1:0] cnt_next;
	logic [CW:0]   n2;
	logic [PW-1:0] n2m1;
	logic [CW-1:0] nm1;
	logic [PW-1:0] ij_addr;
	logic [PW-1:0] in_addr;
	logic          out_load;

	logic          p_we;
	logic [PW-1:0] p_waddr;
	logic [W-1:0]  p_wdata;
	logic [PW-1:0] p_raddr;
	logic          r_we;
	logic [AW-1:0] r_waddr;
	logic [W-1:0]  r_wdata;

	logic [W-1:0]  a_rd;
	logic [W-1:0]  b_rd;
	logic [W-1:0]  m_rd;
	logic [W-1:0]  p_rd;
	logic [W-1:0]  r_rd;

	mmul_pkg::unit_ctrl_t ctrl;
	logic [W-1:0]  acc_lo;
	logic [W-1:0]  carry;
	logic [W-1:0]  sh_word;
	logic [W-1:0]  diff_word;
	logic          ge;

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc = s_tvalid && s_tready;
	assign store_en = in_acc && (cnt_q < CW'(MAX_WORDS));
	assign cnt_next = store_en ? CW'(cnt_q + CW'(1)) : cnt_q;
	assign n2 = {n_q, 1'b0};
	assign n2m1 = PW'(n2 - (CW + 1)'(1));
	assign nm1 = CW'(n_q - CW'(1));
	assign ij_addr = PW'({1'b0, i_q} + {1'b0, j_q});
	assign in_addr = PW'({1'b0, i_q} + {1'b0, n_q});
	assign out_load = (state_q == ST_OUT_LD) && (!ovalid_q || m_tready);

	always_comb begin
		ctrl = '0;
		p_we = 1'b0;
		p_waddr = pc_q;
		p_wdata = '0;
		p_raddr = ij_addr;
		r_we = 1'b0;
		r_waddr = k_q[AW-1:0];
		r_wdata = ge_q ? diff_word : sh_word;
		case (state_q)
			ST_CLEAR: begin
				ctrl.carry_clr = 1'b1;
				p_we = 1'b1;
				r_we = ({1'b0, pc_q} < (PW + 1)'(n_q));
				r_waddr = pc_q[AW-1:0];
				r_wdata = '0;
			end
			ST_PR_MUL: begin
				ctrl.mul_en = 1'b1;
			end
			ST_PR_ACC: begin
				ctrl.acc_en = 1'b1;
				p_we = 1'b1;
				p_waddr = ij_addr;
				p_wdata = acc_lo;
			end
			ST_PR_CAR: begin
				ctrl.carry_clr = 1'b1;
				p_we = 1'b1;
				p_waddr = in_addr;
				p_wdata = carry;
			end
			ST_RW_RD, ST_RW_LD: begin
				p_raddr = wdx_q;
			end
			ST_S1_CMP: begin
				ctrl.sub_en = 1'b1;
				ctrl.sub_first = (k_q == '0);
			end
			ST_S2_WR: begin
				ctrl.sub_en = 1'b1;
				ctrl.sub_first = (k_q == '0);
				r_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mmul_ram #(.WIDTH(W), .DEPTH(MAX_WORDS)) u_a_ram (
		.clk(clk), .we(store_en), .waddr(cnt_q[AW-1:0]), .wdata(s_tdata[31:0]),
		.raddr(j_q[AW-1:0]), .rdata(a_rd)
	);

	mmul_ram #(.WIDTH(W), .DEPTH(MAX_WORDS)) u_b_ram (
		.clk(clk), .we(store_en), .waddr(cnt_q[AW-1:0]), .wdata(s_tdata[63:32]),
		.raddr(i_q[AW-1:0]), .rdata(b_rd)
	);

	mmul_ram #(.WIDTH(W), .DEPTH(MAX_WORDS)) u_m_ram (
		.clk(clk), .we(store_en), .waddr(cnt_q[AW-1:0]), .wdata(s_tdata[95:64]),
		.raddr(k_q[AW-1:0]), .rdata(m_rd)
	);

	mmul_ram #(.WIDTH(W), .DEPTH(2 * MAX_WORDS)) u_p_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);

	mmul_ram #(.WIDTH(W), .DEPTH(MAX_WORDS)) u_r_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(k_q[AW-1:0]), .rdata(r_rd)
	);

	mmul_unit u_unit (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.a_word(a_rd), .b_word(b_rd), .p_word(p_rd),
		.r_word(r_rd), .m_word(m_rd), .bit_in(pw_q[W-1]),
		.acc_lo(acc_lo), .carry(carry), .sh_word(sh_word),
		.diff_word(diff_word), .ge(ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			nz_q <= 1'b0;
			n_q <= '0;
			status_q <= mmul_pkg::STATUS_OK;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			pc_q <= '0;
			wdx_q <= '0;
			bit_q <= '0;
			ge_q <= 1'b0;
			oidx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_tready && !out_load) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (!s_tlast) begin
							cnt_q <= cnt_next;
							if (store_en) begin
								nz_q <= nz_q || (s_tdata[95:64] != '0);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							n_q <= cnt_next;
							cnt_q <= '0;
							ovf_q <= 1'b0;
							nz_q <= 1'b0;
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
							pc_q <= '0;
							oidx_q <= '0;
							if (!(nz_q || (store_en && (s_tdata[95:64] != '0)))) begin
								status_q <= mmul_pkg::STATUS_ZERO_MOD;
								state_q <= ST_OUT_RD;
							end else begin
								status_q <= (ovf_q || !store_en) ?
									mmul_pkg::STATUS_OVERFLOW : mmul_pkg::STATUS_OK;
								state_q <= ST_CLEAR;
							end
						end
					end
				end
				ST_CLEAR: begin
					pc_q <= PW'(pc_q + PW'(1));
					if (pc_q == n2m1) begin
						state_q <= ST_PR_RD;
					end
				end
				ST_PR_RD: begin
					state_q <= ST_PR_MUL;
				end
				ST_PR_MUL: begin
					state_q <= ST_PR_ACC;
				end
				ST_PR_ACC: begin
					if (j_q == nm1) begin
						state_q <= ST_PR_CAR;
					end else begin
						j_q <= CW'(j_q + CW'(1));
						state_q <= ST_PR_RD;
					end
				end
				ST_PR_CAR: begin
					j_q <= '0;
					if (i_q == nm1) begin
						wdx_q <= n2m1;
						state_q <= ST_RW_RD;
					end else begin
						i_q <= CW'(i_q + CW'(1));
						state_q <= ST_PR_RD;
					end
				end
				ST_RW_RD: begin
					state_q <= ST_RW_LD;
				end
				ST_RW_LD: begin
					pw_q <= p_rd;
					bit_q <= 5'd31;
					k_q <= '0;
					state_q <= ST_S1_RD;
				end
				ST_S1_RD: begin
					state_q <= ST_S1_CMP;
				end
				ST_S1_CMP: begin
					if (k_q == nm1) begin
						ge_q <= ge;
						k_q <= '0;
						state_q <= ST_S2_RD;
					end else begin
						k_q <= CW'(k_q + CW'(1));
						state_q <= ST_S1_RD;
					end
				end
				ST_S2_RD: begin
					state_q <= ST_S2_WR;
				end
				ST_S2_WR: begin
					if (k_q == nm1) begin
						k_q <= '0;
						pw_q <= {pw_q[W-2:0], 1'b0};
						if (bit_q != '0) begin
							bit_q <= bit_q - 5'd1;
							state_q <= ST_S1_RD;
						end else if (wdx_q != '0) begin
							wdx_q <= PW'(wdx_q - PW'(1));
							state_q <= ST_RW_RD;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end else begin
						k_q <= CW'(k_q + CW'(1));
						state_q <= ST_S2_RD;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (out_load) begin
						ovalid_q <= 1'b1;
						oidx_q <= oidx_q + 3'd1;
						if (k_q == nm1) begin
							k_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q <= CW'(k_q + CW'(1));
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= (status_q == mmul_pkg::STATUS_ZERO_MOD) ? '0 : r_rd;
			oindex_q <= oidx_q;
			olast_q <= (k_q == nm1);
			ostatus_q <= status_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = {5'd0, oindex_q, odata_q};
	assign m_tlast = olast_q;
	assign m_tuser = ostatus_q;

endmodule
